FILE: hw/rtl/padded_message_bit_packer_core_macros.svh
// Assertion macros for the padded message bit packer.
// Used by the packer core and its output queue; no other dependencies.
`ifndef PADDED_MESSAGE_BIT_PACKER_CORE_MACROS_SVH
`define PADDED_MESSAGE_BIT_PACKER_CORE_MACROS_SVH

// Checked property, disabled while reset is asserted.
`define PMBP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked property, also enforced during reset.
`define PMBP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hw/rtl/pmbp_pkg.sv
// Shared types and constants for the padded message bit packer.
// No dependencies; imported by every module of the block.
package pmbp_pkg;

  localparam int WORD_BITS     = 64;
  localparam int FILL_W        = 6;
  localparam int WIDTH_W       = 7;
  localparam int OUT_DEPTH_DEF = 4;

  localparam logic [WIDTH_W-1:0] MSG_BITS_RESET = 7'd64;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [FILL_W-1:0]    fill_t;
  typedef logic [WIDTH_W-1:0]   width_t;

  // Up to two words produced by one message; the second one always ends the stream.
  typedef struct packed {
    logic [1:0] count;
    word_t      word0;
    logic       last0;
    word_t      word1;
  } pmbp_result_t;

  typedef struct packed {
    word_t partial;
    fill_t fill;
  } pmbp_state_t;

endpackage

FILE: hw/rtl/pmbp_pack.sv
// Combinational merge of one masked message into the partial word.
// Depends on pmbp_pkg.
module pmbp_pack
  import pmbp_pkg::*;
(
  input  word_t        message,
  input  word_t        pad_word,
  input  logic         last_message,
  input  width_t       message_bits,
  input  pmbp_state_t  cur,
  output pmbp_result_t res,
  output pmbp_state_t  nxt
);

  width_t         eff_w;
  word_t          mask;
  word_t          val;
  word_t          merged;
  word_t          carry;
  logic [WIDTH_W:0] total;
  logic [WIDTH_W:0] rem;
  width_t         carry_shift;

  always_comb begin
    // zero acts as one, anything above a word acts as a full word
    if (message_bits == '0) begin
      eff_w = width_t'(1);
    end else if (message_bits > width_t'(WORD_BITS)) begin
      eff_w = width_t'(WORD_BITS);
    end else begin
      eff_w = message_bits;
    end
  end

  assign mask   = (eff_w == width_t'(WORD_BITS)) ? '1 : ((word_t'(1) << eff_w) - word_t'(1));
  assign val    = (message ^ pad_word) & mask;
  assign merged = cur.partial | (val << cur.fill);
  assign total  = (WIDTH_W+1)'(cur.fill) + (WIDTH_W+1)'(eff_w);
  assign rem    = total - (WIDTH_W+1)'(WORD_BITS);
  assign carry_shift = width_t'(WORD_BITS) - width_t'(cur.fill);
  assign carry  = (cur.fill == '0) ? '0 : (val >> carry_shift);

  always_comb begin
    res.count = 2'd0;
    res.word0 = merged;
    res.last0 = 1'b0;
    res.word1 = carry;
    nxt.partial = merged;
    nxt.fill    = fill_t'(total);
    if (total >= (WIDTH_W+1)'(WORD_BITS)) begin
      res.count   = 2'd1;
      nxt.partial = carry;
      nxt.fill    = fill_t'(rem);
      if (last_message) begin
        if (rem == '0) begin
          res.last0 = 1'b1;
        end else begin
          res.count = 2'd2;
        end
      end
    end else if (last_message) begin
      res.count = 2'd1;
      res.last0 = 1'b1;
    end
    // a finished stream starts the next one at bit 0
    if (last_message) begin
      nxt.partial = '0;
      nxt.fill    = '0;
    end
  end

endmodule

FILE: hw/rtl/pmbp_out_fifo.sv
// Output word queue: takes up to two words per cycle, delivers one while out_ready is high.
// Depends on pmbp_pkg and the block's assertion macros.
`include "padded_message_bit_packer_core_macros.svh"
module pmbp_out_fifo
  import pmbp_pkg::*;
#(
  parameter int DEPTH = OUT_DEPTH_DEF  // power of two, at least 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  pmbp_result_t push_res,
  output logic         room2,
  output logic         out_valid,
  input  logic         out_ready,
  output word_t        out_packed_word,
  output logic         out_last_word
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  word_t            word_mem [DEPTH];
  logic [DEPTH-1:0] last_mem;

  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [1:0]       push_n;
  logic             pop;
  logic [PTR_W-1:0] wr_ptr_p1;

  assign push_n    = push ? push_res.count : 2'd0;
  assign pop       = out_valid && out_ready;
  assign wr_ptr_p1 = wr_ptr_r + PTR_W'(1);
  assign room2     = count_r <= CNT_W'(DEPTH - 2);

  assign out_valid       = count_r != '0;
  assign out_packed_word = word_mem[rd_ptr_r];
  assign out_last_word   = last_mem[rd_ptr_r];

  always_comb begin
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push_n);
    count_nxt  = count_r + CNT_W'(push_n) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      word_mem[wr_ptr_r] <= push_res.word0;
      last_mem[wr_ptr_r] <= push_res.last0;
    end
    if (push_n == 2'd2) begin
      word_mem[wr_ptr_p1] <= push_res.word1;
      last_mem[wr_ptr_p1] <= 1'b1;
    end
  end

  `PMBP_ASSERT(a_no_overflow, (CNT_W+1)'(count_r) + (CNT_W+1)'(push_n) <= (CNT_W+1)'(DEPTH), "output queue overflow")
  `PMBP_ASSERT(a_ptr_consistent, PTR_W'(rd_ptr_r + PTR_W'(count_r)) == wr_ptr_r, "queue pointers disagree with count")
  `PMBP_ASSERT(a_room_blocks_push, !room2 |-> (push_n == 2'd0), "word pushed without room for two")

endmodule

FILE: hw/rtl/padded_message_bit_packer_core.sv
// Padded message bit packer: one message in, one 64-bit word out per cycle, unless stalled.
// An accepted message waits in the input register until the queue has room for two words.
// Throughput: one message per cycle; a stream-ending message that spills yields two words.
// Output rate is one word per cycle, set by the single read port of the output queue.
// Synchronous active-low reset clears stream state and queue, width resets to 64; no sweep.
// Depends on pmbp_pkg, pmbp_pack, pmbp_out_fifo and the assertion macros.
`include "padded_message_bit_packer_core_macros.svh"
module padded_message_bit_packer_core
  import pmbp_pkg::*;
#(
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   cfg_we,
  input  width_t cfg_wdata,
  input  logic   in_valid,
  output logic   in_ready,
  input  word_t  in_message,
  input  word_t  in_pad_word,
  input  logic   in_last_message,
  output logic   out_valid,
  input  logic   out_ready,
  output word_t  out_packed_word,
  output logic   out_last_word
);

  width_t      message_bits_r;
  logic        hold_valid_r;
  word_t       message_r;
  word_t       pad_word_r;
  logic        last_r;
  pmbp_state_t state_r;
  pmbp_state_t state_nxt;
  pmbp_result_t res;
  logic        room2;
  logic        adv;

  assign adv      = hold_valid_r && room2;
  assign in_ready = !hold_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      message_bits_r <= MSG_BITS_RESET;
      hold_valid_r   <= 1'b0;
      state_r        <= '0;
    end else begin
      if (cfg_we) begin
        message_bits_r <= cfg_wdata;
      end
      if (in_ready) begin
        hold_valid_r <= in_valid;
      end
      if (adv) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      message_r  <= in_message;
      pad_word_r <= in_pad_word;
      last_r     <= in_last_message;
    end
  end

  pmbp_pack u_pack (
    .message      (message_r),
    .pad_word     (pad_word_r),
    .last_message (last_r),
    .message_bits (message_bits_r),
    .cur          (state_r),
    .res          (res),
    .nxt          (state_nxt)
  );

  pmbp_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (adv),
    .push_res        (res),
    .room2           (room2),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_packed_word (out_packed_word),
    .out_last_word   (out_last_word)
  );

  `PMBP_ASSERT(a_last_clears, adv && last_r |=> (state_r.fill == '0 && state_r.partial == '0), "stream state not cleared after last word")
  `PMBP_ASSERT(a_two_only_on_last, (adv && res.count == 2'd2) |-> (last_r && !res.last0), "two words from a non-final message")
  `PMBP_ASSERT(a_last_emits, (adv && last_r) |-> (res.count != 2'd0), "final message produced no word")

endmodule

FILE: test/packed_word_checker.sv
`timescale 1ns / 1ps
// Packed word checker for padded_message_bit_packer_core: tracks the width register,
// predicts the packed stream from each accepted message and compares every output word.
// Depends on pmbp_pkg; instantiated by tb_top next to the core.
module packed_word_checker
  import pmbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  width_t      cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  word_t       in_message,
  input  word_t       in_pad_word,
  input  logic        in_last_message,
  input  logic        out_valid,
  input  logic        out_ready,
  input  word_t       out_packed_word,
  input  logic        out_last_word,
  output int unsigned mismatches,
  output int unsigned words_due,
  output int unsigned words_checked
);

  typedef struct packed {
    word_t bits;
    logic  ends_stream;
  } stream_word_t;

  stream_word_t expected_words[$];
  width_t       width_reg;
  word_t        acc_bits;
  int unsigned  acc_fill;
  int unsigned  fail_total    = 0;
  int unsigned  checked_total = 0;

  function automatic void push_word(input word_t bits, input logic ends_stream);
    stream_word_t entry;
    entry.bits        = bits;
    entry.ends_stream = ends_stream;
    expected_words.push_back(entry);
  endfunction

  // Appends one message to the stream and queues the words it completes.
  function automatic void pack_message(input word_t msg, input word_t pad, input logic last);
    int unsigned width;
    int unsigned total;
    int unsigned spill;
    word_t       value;
    word_t       merged;
    width = width_reg;
    if (width == 0) width = 1;
    if (width > WORD_BITS) width = WORD_BITS;
    value = msg ^ pad;
    if (width < WORD_BITS) value = value & ((word_t'(1) << width) - word_t'(1));
    merged = acc_bits | (value << acc_fill);
    total  = acc_fill + width;
    if (total >= WORD_BITS) begin
      spill = total - WORD_BITS;
      push_word(merged, last && spill == 0);
      acc_bits = (acc_fill == 0) ? '0 : (value >> (WORD_BITS - acc_fill));
      acc_fill = spill;
      // stream ends with bits left over: zero-padded tail word
      if (last && spill != 0) push_word(acc_bits, 1'b1);
    end else begin
      acc_bits = merged;
      acc_fill = total;
      if (last) push_word(merged, 1'b1);
    end
    if (last) begin
      acc_bits = '0;
      acc_fill = 0;
    end
  endfunction

  always @(posedge clk) begin
    stream_word_t seen;
    stream_word_t want;
    if (!rst_n) begin
      width_reg = MSG_BITS_RESET;
      acc_bits  = '0;
      acc_fill  = 0;
      expected_words.delete();
    end else begin
      // retire output first: a word cannot leave on the edge its message enters
      if (out_valid && out_ready) begin
        seen.bits        = out_packed_word;
        seen.ends_stream = out_last_word;
        if (expected_words.size() == 0) begin
          fail_total++;
          if (fail_total <= 10)
            $display("%0t: unexpected word %h last %b", $time, seen.bits, seen.ends_stream);
        end else begin
          want = expected_words.pop_front();
          checked_total++;
          if (seen.bits !== want.bits || seen.ends_stream !== want.ends_stream) begin
            fail_total++;
            if (fail_total <= 10)
              $display("%0t: word mismatch: expected %h last %b, got %h last %b", $time,
                       want.bits, want.ends_stream, seen.bits, seen.ends_stream);
          end
        end
      end
      if (cfg_we) width_reg = cfg_wdata;
      if (in_valid && in_ready) pack_message(in_message, in_pad_word, in_last_message);
    end
    mismatches    <= fail_total;
    words_due     <= expected_words.size();
    words_checked <= checked_total;
  end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for padded_message_bit_packer_core: reset, width loads, directed and
// random message streams under varied handshake pacing. Depends on pmbp_pkg, the core
// and packed_word_checker, which does all prediction and comparison.
module tb_top;
  import pmbp_pkg::*;

  localparam int          DRAIN_CYCLES   = 8;
  localparam int          PACING_MODES   = 3;
  localparam int          MODE_PHASES    = 6;
  localparam int unsigned PHASE_MESSAGES = 100;
  localparam int unsigned SEND_IDLE   [PACING_MODES] = '{33, 73, 0};
  localparam int unsigned RECV_STALL  [PACING_MODES] = '{73, 33, 0};
  localparam width_t      WIDTH_CORNERS [4]          = '{7'd1, 7'd64, 7'd0, 7'd127};

  logic   clk             = 1'b0;
  logic   rst_n           = 1'b0;
  logic   cfg_we          = 1'b0;
  width_t cfg_wdata       = MSG_BITS_RESET;
  logic   in_valid        = 1'b0;
  word_t  in_message      = '0;
  word_t  in_pad_word     = '0;
  logic   in_last_message = 1'b0;
  logic   out_ready       = 1'b0;
  logic   in_ready;
  logic   out_valid;
  word_t  out_packed_word;
  logic   out_last_word;

  int unsigned mismatches;
  int unsigned words_due;
  int unsigned words_checked;
  int unsigned send_idle_pct = SEND_IDLE[0];
  int unsigned stall_pct     = RECV_STALL[0];
  int unsigned messages_sent = 0;
  int unsigned width_loads   = 0;

  always #2 clk = ~clk;

  padded_message_bit_packer_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_message      (in_message),
    .in_pad_word     (in_pad_word),
    .in_last_message (in_last_message),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_packed_word (out_packed_word),
    .out_last_word   (out_last_word)
  );

  packed_word_checker u_words (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_message      (in_message),
    .in_pad_word     (in_pad_word),
    .in_last_message (in_last_message),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_packed_word (out_packed_word),
    .out_last_word   (out_last_word),
    .mismatches      (mismatches),
    .words_due       (words_due),
    .words_checked   (words_checked)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic word_t pick_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_message(input word_t msg, input word_t pad, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_message      <= msg;
    in_pad_word     <= pad;
    in_last_message <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    messages_sent++;
  endtask

  // Width changes only once every queued word is out and the core has settled.
  task automatic load_width(input width_t width);
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= width;
    @(posedge clk);
    cfg_we <= 1'b0;
    width_loads++;
  endtask

  // Mostly complete streams of random length; the rest are loose words with random flush.
  task automatic stream_messages(input int unsigned count);
    int unsigned sent;
    int unsigned run_len;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 85) begin
        run_len = ($urandom_range(9) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 10);
        for (int unsigned k = 0; k < run_len; k++)
          send_message(pick_word(), pick_word(), k == run_len - 1);
        sent += run_len;
      end else begin
        send_message(pick_word(), pick_word(), $urandom_range(3) == 0);
        sent++;
      end
    end
  endtask

  initial begin
    #(2_000_000);
    $display("Timeout with %0d words still expected", words_due);
    $display("FAIL padded_message_bit_packer_core");
    $finish;
  end

  initial begin
    width_t next_width;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset width of 64: every message fills a word, flush lands exactly
    send_message('1, '0, 1'b0);
    send_message('0, '1, 1'b1);
    send_message(64'hA5A5_5A5A_0F0F_F0F0, 64'hA5A5_5A5A_0F0F_F0F0, 1'b1);
    // zero width saturates to one bit
    load_width(7'd0);
    send_message(64'h1, '0, 1'b0);
    send_message('0, '0, 1'b0);
    send_message('1, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1);
    // 80 bits: full word plus padded tail on the flush
    load_width(7'd40);
    send_message(pick_word(), pick_word(), 1'b0);
    send_message(pick_word(), pick_word(), 1'b1);
    load_width(7'd32);
    send_message(pick_word(), pick_word(), 1'b0);
    send_message(pick_word(), pick_word(), 1'b1);
    // widths past 64 clamp
    load_width(7'd127);
    send_message(pick_word(), pick_word(), 1'b0);
    send_message(pick_word(), pick_word(), 1'b1);
    load_width(7'd1);
    send_message('1, '0, 1'b1);
    load_width(7'd63);
    send_message(pick_word(), pick_word(), 1'b0);
    send_message(pick_word(), pick_word(), 1'b0);
    send_message(pick_word(), pick_word(), 1'b1);

    for (int mode = 0; mode < PACING_MODES; mode++) begin
      send_idle_pct = SEND_IDLE[mode];
      stall_pct     = RECV_STALL[mode];
      for (int ph = 0; ph < MODE_PHASES; ph++) begin
        if (ph < 4) next_width = WIDTH_CORNERS[ph];
        else next_width = width_t'($urandom_range(127));
        load_width(next_width);
        stream_messages(PHASE_MESSAGES);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d messages over %0d width loads, incl. clamped and saturated widths.",
             messages_sent, width_loads);
    $display("Compared %0d packed words under heavy, light and no handshake stalls.",
             words_checked);
    if (mismatches == 0) begin
      $display("PASS padded_message_bit_packer_core");
    end else begin
      $display("FAIL padded_message_bit_packer_core");
    end
    $finish;
  end

endmodule
